// File: design/fnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fnf_pkg;

    // Fixed by the field widths of the stream and register interfaces
    localparam int CH_N     = 2;
    localparam int LVL_W    = 12;
    localparam int STRIDE_W = LVL_W + 1;   // signed ramp increment
    localparam int NEXT_W   = LVL_W + 2;   // signed running ramp value
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_SET_LEVEL = 2'd0,
        OP_DIM       = 2'd1,
        OP_RESTORE   = 2'd2,
        OP_TICK      = 2'd3
    } fnf_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ABOVE_MAX = 2'd1,
        ST_ABSENT    = 2'd2
    } fnf_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_LEVEL   = 3'd0,
        REG_NIGHT_DIS   = 3'd1,
        REG_MAX_WHITE   = 3'd2,
        REG_MAX_AMBER   = 3'd3,
        REG_CH_PRESENT  = 3'd4
    } fnf_reg_t;

    typedef struct packed {
        fnf_op_t          op;
        logic             channel;
        logic [LVL_W-1:0] level;
    } fnf_req_t;

    typedef struct packed {
        fnf_status_t      status;
        logic [LVL_W-1:0] white_level;
        logic [LVL_W-1:0] amber_level;
        logic             ramp_busy;
    } fnf_rsp_t;

endpackage

`default_nettype wire

// File: design/fnf_stride.sv
`timescale 1ns / 1ps
`default_nettype none

// stride = (target - start) / RAMP_STEPS, truncated toward zero.
// Magnitude is divided by a reciprocal multiply; with a 24-bit scale the
// floor is exact for any 12-bit magnitude and any step count up to 15.
module fnf_stride import fnf_pkg::*; #(
    parameter int RAMP_STEPS = 10
) (
    input  wire logic [LVL_W-1:0]           target,
    input  wire logic [LVL_W-1:0]           start,
    output      logic signed [STRIDE_W-1:0] stride
);

    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS));

    logic signed [STRIDE_W-1:0]   diff;
    logic                         neg;
    logic [LVL_W-1:0]             mag;
    logic [LVL_W+RECIP_W-1:0]     prod;
    logic [LVL_W-1:0]             quo;

    always_comb begin
        diff = $signed({1'b0, target}) - $signed({1'b0, start});
        neg  = diff[STRIDE_W-1];
        mag  = neg ? LVL_W'(-diff) : diff[LVL_W-1:0];
        prod = (LVL_W+RECIP_W)'(mag) * (LVL_W+RECIP_W)'(RECIP);
        quo  = prod[RECIP_SHIFT +: LVL_W];
        stride = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end

endmodule

`default_nettype wire

// File: design/fnf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Level state, ramp sequencer, config registers and result register.
// All level and ramp state is read and rewritten in the same cycle an item is taken.
module fnf_ctrl import fnf_pkg::*; #(
    parameter int RAMP_STEPS        = 10,
    parameter int START_DELAY_TICKS = 5
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LVL_W-1:0]     cfg_data,
    input  wire logic                 req_valid,
    input  wire fnf_req_t             req,
    output      logic                 req_ready,
    output      logic                 rsp_valid,
    input  wire logic                 rsp_ready,
    output      fnf_rsp_t             rsp
);

    localparam int IDX_W = $clog2(RAMP_STEPS + 1);
    localparam int DLY_W = (START_DELAY_TICKS > 0) ? $clog2(START_DELAY_TICKS + 1) : 1;

    // config
    logic [LVL_W-1:0] dim_level_reg;
    logic             night_dis_reg;
    logic [LVL_W-1:0] max_reg [CH_N];
    logic [CH_N-1:0]  present_reg;

    // level and ramp state
    logic [LVL_W-1:0]           applied_reg [CH_N], applied_next [CH_N];
    logic [LVL_W-1:0]           user_reg    [CH_N], user_next    [CH_N];
    logic [LVL_W-1:0]           start_reg   [CH_N], start_next   [CH_N];
    logic [LVL_W-1:0]           target_reg  [CH_N], target_next  [CH_N];
    logic signed [STRIDE_W-1:0] stride_reg  [CH_N], stride_next  [CH_N];
    logic signed [NEXT_W-1:0]   rnext_reg   [CH_N], rnext_next   [CH_N];
    logic [IDX_W-1:0]           index_reg, index_next;
    logic [DLY_W-1:0]           delay_reg, delay_next;
    logic                       active_reg, active_next;

    logic                       rsp_valid_reg;
    fnf_rsp_t                   rsp_reg;
    fnf_status_t                status_next;

    logic [LVL_W-1:0]           restore_target [CH_N];
    logic signed [STRIDE_W-1:0] stride_calc    [CH_N];
    logic                       fire;
    logic                       last_step;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign last_step = index_reg >= IDX_W'(RAMP_STEPS);

    for (genvar g = 0; g < CH_N; g++) begin : g_stride
        assign restore_target[g] = present_reg[g] ? user_reg[g] : '0;
        fnf_stride #(.RAMP_STEPS(RAMP_STEPS)) u_stride (
            .target (restore_target[g]),
            .start  (start_reg[g]),
            .stride (stride_calc[g])
        );
    end

    always_comb begin
        applied_next = applied_reg;
        user_next    = user_reg;
        start_next   = start_reg;
        target_next  = target_reg;
        stride_next  = stride_reg;
        rnext_next   = rnext_reg;
        index_next   = index_reg;
        delay_next   = delay_reg;
        active_next  = active_reg;
        status_next  = ST_OK;
        if (fire) begin
            unique case (req.op)
                OP_SET_LEVEL: begin
                    if (!present_reg[req.channel]) begin
                        status_next = ST_ABSENT;
                    end else if (req.level > max_reg[req.channel]) begin
                        status_next = ST_ABOVE_MAX;
                    end else begin
                        applied_next[req.channel] = req.level;
                        user_next[req.channel]    = req.level;
                    end
                end
                OP_DIM: begin
                    if (!night_dis_reg) begin
                        for (int c = 0; c < CH_N; c++) begin
                            if (present_reg[c]) begin
                                start_next[c] = dim_level_reg;
                                if (user_reg[c] != '0 && dim_level_reg <= max_reg[c]) begin
                                    applied_next[c] = dim_level_reg;
                                end
                            end
                        end
                    end
                end
                OP_RESTORE: begin
                    if (!night_dis_reg) begin
                        for (int c = 0; c < CH_N; c++) begin
                            target_next[c] = restore_target[c];
                            stride_next[c] = stride_calc[c];
                            rnext_next[c]  = $signed({2'b00, start_reg[c]})
                                           + NEXT_W'(stride_calc[c]);
                        end
                        index_next  = '0;
                        delay_next  = DLY_W'(START_DELAY_TICKS);
                        active_next = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (active_reg) begin
                        if (delay_reg != '0) begin
                            delay_next = delay_reg - 1'b1;
                        end else begin
                            for (int c = 0; c < CH_N; c++) begin
                                if (target_reg[c] != '0) begin
                                    if (last_step) begin
                                        if (present_reg[c] && target_reg[c] <= max_reg[c]) begin
                                            applied_next[c] = target_reg[c];
                                        end
                                    end else if (rnext_reg[c][NEXT_W-1:LVL_W] == '0
                                                 && present_reg[c]
                                                 && rnext_reg[c][LVL_W-1:0] <= max_reg[c]) begin
                                        applied_next[c] = rnext_reg[c][LVL_W-1:0];
                                    end
                                    rnext_next[c] = rnext_reg[c] + NEXT_W'(stride_reg[c]);
                                end
                            end
                            if (last_step) begin
                                active_next = 1'b0;
                                index_next  = '0;
                            end else begin
                                index_next  = index_reg + 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_level_reg <= '0;
            night_dis_reg <= 1'b0;
            present_reg   <= '1;
            for (int c = 0; c < CH_N; c++) begin
                max_reg[c]     <= '1;
                applied_reg[c] <= '0;
                user_reg[c]    <= '0;
                start_reg[c]   <= '0;
                target_reg[c]  <= '0;
                stride_reg[c]  <= '0;
                rnext_reg[c]   <= '0;
            end
            index_reg     <= '0;
            delay_reg     <= '0;
            active_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (fnf_reg_t'(cfg_index))
                    REG_DIM_LEVEL:  dim_level_reg <= cfg_data;
                    REG_NIGHT_DIS:  night_dis_reg <= cfg_data[0];
                    REG_MAX_WHITE:  max_reg[0]    <= cfg_data;
                    REG_MAX_AMBER:  max_reg[1]    <= cfg_data;
                    REG_CH_PRESENT: present_reg   <= cfg_data[CH_N-1:0];
                    default: ;
                endcase
            end
            applied_reg <= applied_next;
            user_reg    <= user_next;
            start_reg   <= start_next;
            target_reg  <= target_next;
            stride_reg  <= stride_next;
            rnext_reg   <= rnext_next;
            index_reg   <= index_next;
            delay_reg   <= delay_next;
            active_reg  <= active_next;
            if (fire) begin
                rsp_valid_reg <= 1'b1;
            end else if (rsp_ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with the post-update state
    always_ff @(posedge aclk) begin
        if (fire) begin
            rsp_reg.status      <= status_next;
            rsp_reg.white_level <= applied_next[0];
            rsp_reg.amber_level <= applied_next[1];
            rsp_reg.ramp_busy   <= active_next;
        end
    end

    a_delay_only_when_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (delay_reg != '0) |-> active_reg)
        else $error("start delay pending with no ramp active");

    a_index_held_in_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        (delay_reg != '0) |-> (index_reg == '0))
        else $error("ramp index advanced during start delay");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        index_reg <= IDX_W'(RAMP_STEPS))
        else $error("ramp index past last step");

    a_set_white_applies: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && req.op == OP_SET_LEVEL && req.channel == 1'b0 && status_next == ST_OK)
        |=> (applied_reg[0] == $past(req.level) && user_reg[0] == $past(req.level)))
        else $error("accepted white set did not land");

    a_busy_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid_reg |-> (rsp_reg.ramp_busy == active_reg))
        else $error("result busy flag out of step with ramp state");

endmodule

`default_nettype wire

// File: design/frontlight_night_fade.sv
// Path: a request is taken into an input register, and its result is then loaded
//   into the output register, which drives m_axis_tvalid.
// Throughput: one request per cycle while m_axis_tready is not held low; all level
//   and ramp state is updated between the input and output registers.
// Reset: synchronous, active low; clears levels and ramp state, loads config defaults.
`timescale 1ns / 1ps
`default_nettype none

module frontlight_night_fade import fnf_pkg::*; #(
    parameter int RAMP_STEPS        = 10,
    parameter int START_DELAY_TICKS = 5
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // config write channel
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LVL_W-1:0]     cfg_data,
    // request stream
    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,   // [11:0] level, rest zero
    input  wire logic [2:0]           s_axis_tuser,   // [1:0] operation, [2] channel
    // result stream
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output      logic [31:0]          m_axis_tdata    // [1:0] status, [13:2] white_level,
                                                      // [25:14] amber_level, [26] ramp_busy
);

    logic      in_valid_reg;
    fnf_req_t  in_req_reg;
    logic      req_ready;
    fnf_rsp_t  rsp;

    // config registers take a write every cycle
    assign cfg_ready = 1'b1;

    // input stage frees up in the same cycle the core takes the request
    assign s_axis_tready = !in_valid_reg || req_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (req_ready) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_req_reg.op      <= fnf_op_t'(s_axis_tuser[1:0]);
            in_req_reg.channel <= s_axis_tuser[2];
            in_req_reg.level   <= s_axis_tdata[LVL_W-1:0];
        end
    end

    fnf_ctrl #(
        .RAMP_STEPS        (RAMP_STEPS),
        .START_DELAY_TICKS (START_DELAY_TICKS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (in_valid_reg),
        .req       (in_req_reg),
        .req_ready (req_ready),
        .rsp_valid (m_axis_tvalid),
        .rsp_ready (m_axis_tready),
        .rsp       (rsp)
    );

    assign m_axis_tdata = {5'b0, rsp.ramp_busy, rsp.amber_level, rsp.white_level, rsp.status};

endmodule

`default_nettype wire

// File: bench/frontlight_night_fade_tb.sv
`timescale 1ns / 1ps

module frontlight_night_fade_tb;
    import fnf_pkg::*;

    // Ramp shape of the block at its default parameters
    localparam int STEPS_PER_RAMP   = 10;
    localparam int HOLD_TICKS       = 5;
    localparam int LEVEL_MAX        = (1 << LVL_W) - 1;
    // Far above the slowest legal run
    localparam int CYCLE_LIMIT      = 200000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int RANDOM_REQUESTS  = 230;

    // One result as carried in m_axis_tdata
    typedef struct packed {
        fnf_status_t      status;
        logic [LVL_W-1:0] white;
        logic [LVL_W-1:0] amber;
        logic             busy;
    } light_state_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [LVL_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata  = '0;   // [11:0] level, rest zero
    logic [2:0]           s_axis_tuser  = '0;   // [1:0] operation, [2] channel
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;         // [1:0] status, [13:2] white,
                                                // [25:14] amber, [26] ramp_busy

    // Flow-control mix, changed between test phases
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;

    int cycle_count    = 0;
    int sent_count     = 0;
    int checked_count  = 0;
    int mismatch_count = 0;
    int reg_writes     = 0;
    int ramps_done     = 0;

    // Results still owed by the block, oldest first
    light_state_t expected_lights[$];

    // Predictor state: configuration copy
    int         night_dim;
    bit         night_off;
    int         level_cap [CH_N];
    logic [1:0] chan_on;
    // Predictor state: levels and ramp
    int lvl_applied [CH_N];
    int lvl_user    [CH_N];
    int fade_from   [CH_N];
    int fade_to     [CH_N];
    int fade_step   [CH_N];
    int fade_next   [CH_N];
    int fade_index;
    int fade_hold;
    bit fade_on;

    frontlight_night_fade dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run guard: a hung handshake ends here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run stopped at cycle limit %0d, %0d results outstanding",
                     CYCLE_LIMIT, expected_lights.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_axis_tready <= aresetn && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Any write, user or ramp, goes through the same presence and cap checks
    function automatic fnf_status_t drive_level(int c, int lvl, bit from_user);
        if (!chan_on[c])
            return ST_ABSENT;
        if (lvl > level_cap[c])
            return ST_ABOVE_MAX;
        lvl_applied[c] = lvl;
        if (from_user)
            lvl_user[c] = lvl;
        return ST_OK;
    endfunction

    // Light state after one request; updates the predictor state
    function automatic light_state_t predict_light(fnf_op_t op, logic ch,
                                                   logic [LVL_W-1:0] lvl);
        light_state_t r;
        int v;
        r.status = ST_OK;
        case (op)
            OP_SET_LEVEL: begin
                r.status = drive_level(ch, lvl, 1'b1);
            end
            OP_DIM: begin
                if (!night_off) begin
                    for (int c = 0; c < CH_N; c++) begin
                        if (chan_on[c]) begin
                            fade_from[c] = night_dim;
                            // dark channels stay dark
                            if (lvl_user[c] != 0)
                                void'(drive_level(c, night_dim, 1'b0));
                        end
                    end
                end
            end
            OP_RESTORE: begin
                if (!night_off) begin
                    for (int c = 0; c < CH_N; c++) begin
                        // absent channel gets a zero target and is skipped
                        fade_to[c]   = chan_on[c] ? lvl_user[c] : 0;
                        // signed divide truncates toward zero
                        fade_step[c] = (fade_to[c] - fade_from[c]) / STEPS_PER_RAMP;
                        fade_next[c] = fade_from[c] + fade_step[c];
                    end
                    fade_index = 0;
                    fade_hold  = HOLD_TICKS;
                    fade_on    = 1'b1;
                end
            end
            default: begin
                if (fade_on) begin
                    if (fade_hold > 0) begin
                        fade_hold--;
                    end else begin
                        for (int c = 0; c < CH_N; c++) begin
                            if (fade_to[c] != 0) begin
                                // last step lands exactly on the target
                                v = (fade_index >= STEPS_PER_RAMP) ? fade_to[c]
                                                                   : fade_next[c];
                                if (v >= 0)
                                    void'(drive_level(c, v, 1'b0));
                                fade_next[c] += fade_step[c];
                            end
                        end
                        if (fade_index >= STEPS_PER_RAMP) begin
                            fade_on    = 1'b0;
                            fade_index = 0;
                            ramps_done++;
                        end else begin
                            fade_index++;
                        end
                    end
                end
            end
        endcase
        r.white = LVL_W'(lvl_applied[0]);
        r.amber = LVL_W'(lvl_applied[1]);
        r.busy  = fade_on;
        return r;
    endfunction

    // Send one request; called and returns at a falling edge, tvalid left high
    task automatic push_request(input fnf_op_t op, input logic ch,
                                input logic [LVL_W-1:0] lvl);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, lvl};
        s_axis_tuser  <= {ch, op};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        expected_lights.push_back(predict_light(op, ch, lvl));
        sent_count++;
        @(negedge aclk);
    endtask

    // Random request of any kind, unused fields random too
    task automatic push_any();
        push_request(fnf_op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     LVL_W'($urandom_range(0, LEVEL_MAX)));
    endtask

    // Block counts as idle once every result is back plus its pipeline depth
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_lights.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input fnf_reg_t idx, input logic [LVL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_DIM_LEVEL:  night_dim    = val;
            REG_NIGHT_DIS:  night_off    = val[0];
            REG_MAX_WHITE:  level_cap[0] = val;
            REG_MAX_AMBER:  level_cap[1] = val;
            REG_CH_PRESENT: chan_on      = val[1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input int dim, input bit off, input int max_w,
                              input int max_a, input logic [1:0] present);
        wait_idle();
        write_reg(REG_DIM_LEVEL, LVL_W'(dim));
        write_reg(REG_NIGHT_DIS, LVL_W'(off));
        write_reg(REG_MAX_WHITE, LVL_W'(max_w));
        write_reg(REG_MAX_AMBER, LVL_W'(max_a));
        write_reg(REG_CH_PRESENT, LVL_W'(present));
    endtask

    // Register value leaning on the extremes
    function automatic int edge_biased();
        case ($urandom_range(0, 9))
            0:       return 0;
            1, 2:    return LEVEL_MAX;
            default: return $urandom_range(0, LEVEL_MAX);
        endcase
    endfunction

    // Request level: extremes, anything, or something the cap lets through
    function automatic int pick_level(int c);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return LEVEL_MAX;
            2, 3:    return $urandom_range(0, LEVEL_MAX);
            default: return $urandom_range(0, level_cap[c]);
        endcase
    endfunction

    // Level writes: field extremes, caps and absent channels
    task automatic test_set_level();
        push_request(OP_SET_LEVEL, 1'b0, 12'hFFF);
        push_request(OP_SET_LEVEL, 1'b1, 12'h000);
        push_request(OP_SET_LEVEL, 1'b1, 12'hFFF);
        push_request(OP_SET_LEVEL, 1'b0, 12'h000);
        push_request(OP_SET_LEVEL, 1'b0, 12'h555);
        push_request(OP_SET_LEVEL, 1'b1, 12'hAAA);
        // white absent, amber capped at zero
        set_config(0, 1'b0, 100, 0, 2'b10);
        push_request(OP_SET_LEVEL, 1'b0, 12'd50);
        push_request(OP_SET_LEVEL, 1'b1, 12'd1);
        push_request(OP_SET_LEVEL, 1'b1, 12'd0);
        set_config(0, 1'b0, LEVEL_MAX, LEVEL_MAX, 2'b11);
    endtask

    // Full dim / restore cycle: restart, dim mid-ramp, idle ticks
    task automatic test_fade_ramp();
        set_config(200, 1'b0, LEVEL_MAX, LEVEL_MAX, 2'b11);
        push_request(OP_SET_LEVEL, 1'b0, 12'd3000);
        push_request(OP_SET_LEVEL, 1'b1, 12'd0);      // amber has a zero target
        push_request(OP_DIM, 1'b1, 12'hFFF);
        push_request(OP_TICK, 1'b0, 12'd0);           // tick with no ramp
        push_request(OP_RESTORE, 1'b0, 12'd0);
        repeat (2) push_request(OP_TICK, 1'b1, 12'd0);
        push_request(OP_RESTORE, 1'b1, 12'd7);        // restart from the hold
        push_request(OP_DIM, 1'b0, 12'd0);            // ramp keeps going
        repeat (HOLD_TICKS + STEPS_PER_RAMP + 2) push_request(OP_TICK, 1'b0, 12'd0);
    endtask

    // Downward ramp, absent channel at restore, cap lowered mid-ramp, disable
    task automatic test_fade_corners();
        set_config(LEVEL_MAX, 1'b0, LEVEL_MAX, LEVEL_MAX, 2'b01);
        push_request(OP_SET_LEVEL, 1'b0, 12'd3);
        push_request(OP_SET_LEVEL, 1'b1, 12'd9);      // amber absent
        push_request(OP_DIM, 1'b0, 12'd0);
        push_request(OP_RESTORE, 1'b0, 12'd0);
        repeat (HOLD_TICKS + 2) push_request(OP_TICK, 1'b0, 12'd0);
        // steps above the new white cap get dropped
        set_config(LEVEL_MAX, 1'b0, 1000, LEVEL_MAX, 2'b11);
        repeat (STEPS_PER_RAMP) push_request(OP_TICK, 1'b0, 12'd0);
        set_config(0, 1'b1, LEVEL_MAX, 0, 2'b11);
        push_request(OP_SET_LEVEL, 1'b0, 12'd800);
        push_request(OP_DIM, 1'b0, 12'd0);
        push_request(OP_RESTORE, 1'b0, 12'd0);
        push_request(OP_TICK, 1'b0, 12'd0);
    endtask

    // Mostly well-formed nights (set, dim, restore, ticks) with random content,
    // mixed with plain noise; config redrawn each phase
    task automatic test_random_nights(input int n_requests);
        int stop_at;
        int phase_end;
        stop_at = sent_count + n_requests;
        while (sent_count < stop_at) begin
            set_config(edge_biased(), $urandom_range(0, 5) == 0, edge_biased(),
                       edge_biased(),
                       ($urandom_range(0, 7) < 5) ? 2'b11 : 2'($urandom_range(0, 3)));
            phase_end = sent_count + $urandom_range(40, 70);
            while (sent_count < phase_end) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) push_any();
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        automatic logic c = 1'($urandom_range(0, 1));
                        push_request(OP_SET_LEVEL, c, LVL_W'(pick_level(c)));
                    end
                    push_request(OP_DIM, 1'($urandom_range(0, 1)),
                                 LVL_W'($urandom_range(0, LEVEL_MAX)));
                    repeat ($urandom_range(0, 2))
                        push_request(OP_TICK, 1'($urandom_range(0, 1)),
                                     LVL_W'($urandom_range(0, LEVEL_MAX)));
                    push_request(OP_RESTORE, 1'($urandom_range(0, 1)),
                                 LVL_W'($urandom_range(0, LEVEL_MAX)));
                    // a stray request now and then lands mid-ramp
                    repeat ($urandom_range(8, 20)) begin
                        if ($urandom_range(0, 9) == 0)
                            push_any();
                        else
                            push_request(OP_TICK, 1'($urandom_range(0, 1)),
                                         LVL_W'($urandom_range(0, LEVEL_MAX)));
                    end
                end
            end
        end
    endtask

    // Compare every accepted result with the oldest prediction
    always @(posedge aclk) begin : result_check
        light_state_t seen;
        light_state_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen.status = fnf_status_t'(m_axis_tdata[1:0]);
            seen.white  = m_axis_tdata[13:2];
            seen.amber  = m_axis_tdata[25:14];
            seen.busy   = m_axis_tdata[26];
            checked_count++;
            if (expected_lights.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_MISMATCHES)
                    $display("%0t: result %0d with none outstanding: status %0d white %0d amber %0d busy %0b",
                             $realtime, checked_count, seen.status, seen.white, seen.amber,
                             seen.busy);
            end else begin
                want = expected_lights.pop_front();
                if (seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MISMATCHES)
                        $display("%0t: result %0d expected status %0d white %0d amber %0d busy %0b, got status %0d white %0d amber %0d busy %0b",
                                 $realtime, checked_count, want.status, want.white, want.amber,
                                 want.busy, seen.status, seen.white, seen.amber, seen.busy);
                end
            end
        end
    end

    initial begin : run
        int drain;
        // predictor matches the block's reset state
        night_dim  = 0;
        night_off  = 1'b0;
        level_cap  = '{LEVEL_MAX, LEVEL_MAX};
        chan_on    = 2'b11;
        lvl_applied = '{0, 0};
        lvl_user    = '{0, 0};
        fade_from   = '{0, 0};
        fade_to     = '{0, 0};
        fade_step   = '{0, 0};
        fade_next   = '{0, 0};
        fade_index = 0;
        fade_hold  = 0;
        fade_on    = 1'b0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part and first random part: sender gaps 37, receiver stalls 46
        src_gap_pct    = 37;
        sink_stall_pct = 46;
        test_set_level();
        test_fade_ramp();
        test_fade_corners();

        // random part: three flow-control mixes
        test_random_nights(RANDOM_REQUESTS);
        src_gap_pct    = 46;
        sink_stall_pct = 37;
        test_random_nights(RANDOM_REQUESTS);
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_nights(RANDOM_REQUESTS);

        // drain, then allow the pipeline depth for anything extra
        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (expected_lights.size() != 0 && drain < 5000) begin
            @(negedge aclk);
            drain++;
        end
        repeat (8) @(negedge aclk);
        if (expected_lights.size() != 0) begin
            $display("%0d expected results never arrived", expected_lights.size());
            mismatch_count += expected_lights.size();
        end

        $display("covered %0d requests (set, dim, restore, tick) and %0d register writes",
                 sent_count, reg_writes);
        $display("%0d results compared, %0d ramps ran to completion, %0d mismatches",
                 checked_count, ramps_done, mismatch_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
